/* sv/dad_pkg.sv */
// ----------------------------------------------------------------------------
// dad_pkg
// Shared types, codes and constants for the anchor column box decoder.
// ----------------------------------------------------------------------------
package dad_pkg;

  // widths of the item and result fields
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned INDEX_W  = 7;
  localparam int unsigned VALUE_W  = 18;
  localparam int unsigned SCORE_W  = 16;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned FRAME_W  = 12;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 12;

  localparam int unsigned MAX_CLASSES_DEFAULT = 128;

  localparam logic [SCORE_W-1:0] DEFAULT_THRESHOLD = 16'd16384;

  localparam logic [FRAME_W-1:0] NET_WIDTH_RESET  = 12'd640;
  localparam logic [FRAME_W-1:0] NET_HEIGHT_RESET = 12'd640;
  localparam logic [COUNT_W-1:0] THRESHOLD_COUNT_RESET = 8'd0;

  typedef enum logic [OPCODE_W-1:0] {
    OP_BOX    = 2'd0,
    OP_SCORE  = 2'd1,
    OP_THRESH = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NET_WIDTH       = 2'd0,
    REG_NET_HEIGHT      = 2'd1,
    REG_THRESHOLD_COUNT = 2'd2
  } cfg_reg_t;

  // box slots within the anchor column
  localparam logic [1:0] SLOT_CX = 2'd0;
  localparam logic [1:0] SLOT_CY = 2'd1;
  localparam logic [1:0] SLOT_W  = 2'd2;
  localparam logic [1:0] SLOT_H  = 2'd3;

  // saturate a signed value to unsigned Q0.16
  function automatic logic [SCORE_W-1:0] sat_score(input logic signed [VALUE_W-1:0] v);
    logic [SCORE_W-1:0] r;
    if (v[VALUE_W-1]) begin
      r = '0;
    end else if (v[VALUE_W-2:SCORE_W] != '0) begin
      r = '1;
    end else begin
      r = v[SCORE_W-1:0];
    end
    return r;
  endfunction

  // edge = 2*centre - size in Q.5, clamped to [0, 32*frame], returned in Q12.4
  function automatic logic [COORD_W-1:0] clamp_edge(
    input logic signed [VALUE_W-1:0] centre,
    input logic signed [VALUE_W-1:0] size,
    input logic [FRAME_W-1:0]        frame
  );
    logic signed [VALUE_W+1:0] e5;
    logic        [FRAME_W+4:0] lim5;
    logic        [FRAME_W+4:0] clamped;
    e5   = $signed({centre[VALUE_W-1], centre, 1'b0}) -
           $signed({{2{size[VALUE_W-1]}}, size});
    lim5 = {frame, 5'b0};
    if (e5[VALUE_W+1]) begin
      clamped = '0;
    end else if (e5 > $signed({3'b0, lim5})) begin
      clamped = lim5;
    end else begin
      clamped = e5[FRAME_W+4:0];
    end
    return clamped[FRAME_W+4:1];
  endfunction

endpackage

/* sv/detection_anchor_decode.sv */
// ----------------------------------------------------------------------------
// detection_anchor_decode
// Streams anchor column elements, tracks the best class score and emits one
// clamped, trimmed detection box per anchor that passes its class threshold and keeps a non-empty box.
// ----------------------------------------------------------------------------
// One element is taken every clock cycle while item_stall is low. Each
// element passes an input register, a decode stage that updates the box
// and best-score state and reads the threshold table, and a threshold/trim
// stage feeding the result register, where the detection for the element
// marked last is registered. The threshold table is a single memory of
// MAX_CLASSES entries written by load elements and read once per anchor
// end that has a best class; entries hold no defined value until loaded and
// the table is not cleared at reset. Results wait in the result register
// while new elements keep flowing until both internal stages are full.
module detection_anchor_decode #(
  parameter int unsigned MAX_CLASSES = dad_pkg::MAX_CLASSES_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [dad_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [dad_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic [dad_pkg::OPCODE_W-1:0]           opcode,
  input  logic [dad_pkg::INDEX_W-1:0]            index,
  input  logic signed [dad_pkg::VALUE_W-1:0]     value,
  input  logic                                   last,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic [dad_pkg::INDEX_W-1:0]            class_id,
  output logic [dad_pkg::SCORE_W-1:0]            confidence,
  output logic [dad_pkg::COORD_W-1:0]            left,
  output logic [dad_pkg::COORD_W-1:0]            top,
  output logic [dad_pkg::COORD_W-1:0]            box_width,
  output logic [dad_pkg::COORD_W-1:0]            box_height
);

  localparam int unsigned ADDR_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam logic [8:0]  CLASS_LIMIT = 9'(MAX_CLASSES);

  // configuration
  logic [dad_pkg::FRAME_W-1:0] net_width;
  logic [dad_pkg::FRAME_W-1:0] net_height;
  logic [dad_pkg::COUNT_W-1:0] threshold_count;

  // input register
  logic                                s1_valid;
  logic [dad_pkg::OPCODE_W-1:0]        s1_opcode;
  logic [dad_pkg::INDEX_W-1:0]         s1_index;
  logic signed [dad_pkg::VALUE_W-1:0]  s1_value;
  logic                                s1_last;

  // anchor state
  logic [dad_pkg::SCORE_W-1:0]         best_score;
  logic [dad_pkg::INDEX_W-1:0]         best_class;
  logic                                best_valid;
  logic signed [dad_pkg::VALUE_W-1:0]  box_values [4];

  // threshold table
  logic [dad_pkg::SCORE_W-1:0]         thr_mem [MAX_CLASSES];
  logic [dad_pkg::SCORE_W-1:0]         thr_rd;

  // threshold/trim stage
  logic                                s2_valid;
  logic [dad_pkg::INDEX_W-1:0]         s2_class;
  logic [dad_pkg::SCORE_W-1:0]         s2_score;
  logic                                s2_default;
  logic [dad_pkg::COORD_W-1:0]         s2_left;
  logic [dad_pkg::COORD_W-1:0]         s2_top;
  logic signed [dad_pkg::VALUE_W-1:0]  s2_w;
  logic signed [dad_pkg::VALUE_W-1:0]  s2_h;

  // decode stage logic
  logic                                rdy_out;
  logic                                rdy2;
  logic                                leave;
  logic [dad_pkg::SCORE_W-1:0]         score_sat;
  logic                                class_ok;
  logic                                anchor_end;
  logic                                thr_we;
  logic                                thr_re;
  logic [dad_pkg::SCORE_W-1:0]         eff_score;
  logic [dad_pkg::INDEX_W-1:0]         eff_class;
  logic                                eff_valid;
  logic signed [dad_pkg::VALUE_W-1:0]  eff_box [4];
  logic                                cand;
  logic                                in_table;
  logic [7:0]                          class_ext;
  logic [7:0]                          index_ext;
  logic [ADDR_W-1:0]                   rd_addr;
  logic [ADDR_W-1:0]                   wr_addr;

  // threshold/trim stage logic
  logic [dad_pkg::SCORE_W-1:0]         thr;
  logic [dad_pkg::COORD_W-1:0]         room_w;
  logic [dad_pkg::COORD_W-1:0]         room_h;
  logic signed [dad_pkg::VALUE_W-1:0]  trim_w;
  logic signed [dad_pkg::VALUE_W-1:0]  trim_h;
  logic                                pass;

  assign rdy_out    = !result_valid || !result_stall;
  assign rdy2       = !s2_valid || rdy_out;
  assign item_stall = s1_valid && !rdy2;
  assign leave      = s1_valid && rdy2;

  assign score_sat = dad_pkg::sat_score(s1_value);
  assign class_ok  = {2'b0, s1_index} < CLASS_LIMIT;

  always_comb begin
    eff_score  = best_score;
    eff_class  = best_class;
    eff_valid  = best_valid;
    anchor_end = 1'b0;
    thr_we     = 1'b0;
    for (int i = 0; i < 4; i++) begin
      eff_box[i] = box_values[i];
    end
    case (s1_opcode)
      dad_pkg::OP_BOX: begin
        eff_box[s1_index[1:0]] = s1_value;
        anchor_end = s1_last;
      end
      dad_pkg::OP_SCORE: begin
        if (class_ok && (score_sat > best_score)) begin
          eff_score = score_sat;
          eff_class = s1_index;
          eff_valid = 1'b1;
        end
        anchor_end = s1_last;
      end
      dad_pkg::OP_THRESH: begin
        thr_we = leave && class_ok;
      end
      default: begin
      end
    endcase
  end

  assign cand      = leave && anchor_end && eff_valid;
  assign thr_re    = cand;
  assign in_table  = {1'b0, eff_class} < threshold_count;
  assign class_ext = {1'b0, eff_class};
  assign index_ext = {1'b0, s1_index};
  assign rd_addr   = in_table ? class_ext[ADDR_W-1:0] : '0;
  assign wr_addr   = index_ext[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (thr_we) begin
      thr_mem[wr_addr] <= score_sat;
    end
    if (thr_re) begin
      thr_rd <= thr_mem[rd_addr];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      net_width       <= dad_pkg::NET_WIDTH_RESET;
      net_height      <= dad_pkg::NET_HEIGHT_RESET;
      threshold_count <= dad_pkg::THRESHOLD_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dad_pkg::REG_NET_WIDTH:       net_width       <= cfg_data;
        dad_pkg::REG_NET_HEIGHT:      net_height      <= cfg_data;
        dad_pkg::REG_THRESHOLD_COUNT: threshold_count <= cfg_data[dad_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
    if (item_valid && !item_stall) begin
      s1_opcode <= opcode;
      s1_index  <= index;
      s1_value  <= value;
      s1_last   <= last;
    end
  end

  // anchor state; every anchor end clears the best score
  always_ff @(posedge clk) begin
    if (rst) begin
      best_score <= '0;
      best_class <= '0;
      best_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        box_values[i] <= '0;
      end
    end else if (leave) begin
      for (int i = 0; i < 4; i++) begin
        box_values[i] <= eff_box[i];
      end
      if (anchor_end) begin
        best_score <= '0;
        best_class <= '0;
        best_valid <= 1'b0;
      end else begin
        best_score <= eff_score;
        best_class <= eff_class;
        best_valid <= eff_valid;
      end
    end
  end

  // decode stage to threshold/trim stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (rdy2) begin
      s2_valid <= cand;
    end
    if (cand) begin
      s2_class   <= eff_class;
      s2_score   <= eff_score;
      s2_default <= (threshold_count == '0);
      s2_left    <= dad_pkg::clamp_edge(eff_box[dad_pkg::SLOT_CX], eff_box[dad_pkg::SLOT_W],
                                        net_width);
      s2_top     <= dad_pkg::clamp_edge(eff_box[dad_pkg::SLOT_CY], eff_box[dad_pkg::SLOT_H],
                                        net_height);
      s2_w       <= eff_box[dad_pkg::SLOT_W];
      s2_h       <= eff_box[dad_pkg::SLOT_H];
    end
  end

  // trim to the frame edge; room is never negative after the clamp
  assign room_w = {net_width, 4'b0} - s2_left;
  assign room_h = {net_height, 4'b0} - s2_top;
  assign trim_w = (s2_w < $signed({2'b0, room_w})) ? s2_w : $signed({2'b0, room_w});
  assign trim_h = (s2_h < $signed({2'b0, room_h})) ? s2_h : $signed({2'b0, room_h});
  assign thr    = s2_default ? dad_pkg::DEFAULT_THRESHOLD : thr_rd;
  assign pass   = (s2_score >= thr) &&
                  !trim_w[dad_pkg::VALUE_W-1] && (trim_w != '0) &&
                  !trim_h[dad_pkg::VALUE_W-1] && (trim_h != '0);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (rdy_out) begin
      result_valid <= s2_valid && pass;
    end
    if (rdy_out && s2_valid && pass) begin
      class_id   <= s2_class;
      confidence <= s2_score;
      left       <= s2_left;
      top        <= s2_top;
      box_width  <= trim_w[dad_pkg::COORD_W-1:0];
      box_height <= trim_h[dad_pkg::COORD_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_box_positive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (box_width != '0) && (box_height != '0))
    else $error("detection with empty box");

  a_left_in_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (left <= {net_width, 4'b0}) && (top <= {net_height, 4'b0}))
    else $error("detection corner outside the frame");

  a_table_port: assert property (@(posedge clk) disable iff (rst)
    !(thr_we && thr_re))
    else $error("threshold table written and read by one transaction");

  a_anchor_clear: assert property (@(posedge clk) disable iff (rst)
    cand |=> !best_valid && (best_score == '0))
    else $error("best score kept across an anchor end");
`endif

endmodule

/* test/tb_detection_anchor_decode.sv */
// ----------------------------------------------------------------------------
// tb_detection_anchor_decode
// Drives directed and random anchor columns, threshold loads and stray
// elements into the decoder with random idling on both handshakes. Each
// accepted transaction is decoded by a behavioral copy of the block, and every
// detection that comes out is compared field by field, in order, against that
// copy under several frame sizes and threshold table settings.
// ----------------------------------------------------------------------------
module tb_detection_anchor_decode;
  timeunit 1ns;
  timeprecision 1ps;

  import dad_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CLASS_COUNT    = MAX_CLASSES_DEFAULT;
  localparam int unsigned RANDOM_ITEMS   = 2000;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT   = 200;

  typedef struct packed {
    logic [INDEX_W-1:0] cls;
    logic [SCORE_W-1:0] score;
    logic [COORD_W-1:0] lft;
    logic [COORD_W-1:0] tp;
    logic [COORD_W-1:0] wd;
    logic [COORD_W-1:0] ht;
  } detection_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       item_valid = 1'b0;
  logic                       item_stall;
  logic [OPCODE_W-1:0]        opcode = '0;
  logic [INDEX_W-1:0]         index = '0;
  logic signed [VALUE_W-1:0]  value = '0;
  logic                       last = 1'b0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic [INDEX_W-1:0]         class_id;
  logic [SCORE_W-1:0]         confidence;
  logic [COORD_W-1:0]         left;
  logic [COORD_W-1:0]         top;
  logic [COORD_W-1:0]         box_width;
  logic [COORD_W-1:0]         box_height;

  // predictor copy of configuration and anchor state
  logic [FRAME_W-1:0]         frame_w = NET_WIDTH_RESET;
  logic [FRAME_W-1:0]         frame_h = NET_HEIGHT_RESET;
  logic [COUNT_W-1:0]         thr_count = THRESHOLD_COUNT_RESET;
  logic [SCORE_W-1:0]         top_score = '0;
  logic [INDEX_W-1:0]         top_class = '0;
  bit                         top_found = 1'b0;
  logic signed [VALUE_W-1:0]  box_reg [4] = '{default: '0};
  logic [SCORE_W-1:0]         class_thr [CLASS_COUNT];

  detection_t                 pending_detections [$];
  int unsigned                fail_count = 0;
  int unsigned                items_sent = 0;
  int unsigned                quiet_cycles = 0;
  int unsigned                rx_hold = 0;
  bit                         tx_idling = 1'b1;
  bit                         rx_idling = 1'b1;

  detection_anchor_decode dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .opcode       (opcode),
    .index        (index),
    .value        (value),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .class_id     (class_id),
    .confidence   (confidence),
    .left         (left),
    .top          (top),
    .box_width    (box_width),
    .box_height   (box_height)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [SCORE_W-1:0] clip_q016(logic signed [VALUE_W-1:0] v);
    int s;
    s = v;
    if (s < 0) return '0;
    if (s > 65535) return '1;
    return s[SCORE_W-1:0];
  endfunction

  // clamp the corner to the frame and trim the size to the room left
  function automatic longint fit_axis(
    input  logic signed [VALUE_W-1:0] centre,
    input  logic signed [VALUE_W-1:0] size,
    input  logic [FRAME_W-1:0]        frame,
    output logic [COORD_W-1:0]        corner
  );
    longint c, sz, fr, e5, e4, room;
    c  = centre;
    sz = size;
    fr = frame;
    e5 = 2 * c - sz;
    if (e5 > 32 * fr) e5 = 32 * fr;
    if (e5 < 0) e5 = 0;
    e4 = e5 / 2;
    corner = e4[COORD_W-1:0];
    room = 16 * fr - e4;
    return (sz < room) ? sz : room;
  endfunction

  function automatic void decode_element(
    logic [OPCODE_W-1:0] op,
    logic [INDEX_W-1:0] idx,
    logic signed [VALUE_W-1:0] val,
    bit lst
  );
    logic [SCORE_W-1:0] s, thr;
    logic [COORD_W-1:0] lft_q4, tp_q4;
    longint w_trim, h_trim;
    detection_t d;
    case (op)
      OP_BOX: box_reg[idx[1:0]] = val;
      OP_SCORE: begin
        s = clip_q016(val);
        if (int'(idx) < CLASS_COUNT && s > top_score) begin
          top_score = s;
          top_class = idx;
          top_found = 1'b1;
        end
      end
      OP_THRESH: begin
        if (int'(idx) < CLASS_COUNT) class_thr[idx] = clip_q016(val);
        return;
      end
      default: return;
    endcase
    if (!lst) return;
    if (top_found) begin
      if (top_class < thr_count) begin
        thr = class_thr[top_class];
      end else if (thr_count != 0) begin
        thr = class_thr[0];
      end else begin
        thr = DEFAULT_THRESHOLD;
      end
      if (top_score >= thr) begin
        w_trim = fit_axis(box_reg[SLOT_CX], box_reg[SLOT_W], frame_w, lft_q4);
        h_trim = fit_axis(box_reg[SLOT_CY], box_reg[SLOT_H], frame_h, tp_q4);
        if (w_trim > 0 && h_trim > 0) begin
          d.cls   = top_class;
          d.score = top_score;
          d.lft   = lft_q4;
          d.tp    = tp_q4;
          d.wd    = w_trim[COORD_W-1:0];
          d.ht    = h_trim[COORD_W-1:0];
          pending_detections = {pending_detections, d};
        end
      end
    end
    top_score = '0;
    top_class = '0;
    top_found = 1'b0;
  endfunction

  // ------------------------------------------------------------------ checker

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (fail_count < REPORT_LIMIT)
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    detection_t want;
    if (rst) begin
      rx_hold = 0;
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_detections.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("%0t: detection expected none actual class %0d confidence %0d",
                     $time, class_id, confidence);
          fail_count++;
        end else begin
          want = pending_detections.pop_front();
          check_field("class_id", want.cls, class_id);
          check_field("confidence", want.score, confidence);
          check_field("left", want.lft, left);
          check_field("top", want.tp, top);
          check_field("box_width", want.wd, box_width);
          check_field("box_height", want.ht, box_height);
        end
        rx_hold = rx_idling ? $urandom_range(0, 9) : 0;
      end else if (rx_hold != 0) begin
        rx_hold--;
      end
      result_stall <= (rx_hold != 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("detection_anchor_decode: mismatch");
      $finish;
    end
  end

  // ------------------------------------------------------------------ drivers

  task automatic push_element(
    input logic [OPCODE_W-1:0] op,
    input logic [INDEX_W-1:0] idx,
    input logic signed [VALUE_W-1:0] val,
    input bit lst
  );
    int unsigned gap;
    gap = tx_idling ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode <= op;
    index <= idx;
    value <= val;
    last <= lst;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    decode_element(op, idx, val, lst);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // wait out every detection plus the pipeline, since anchors may end silently
  task automatic settle();
    item_valid <= 1'b0;
    while (pending_detections.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    case (r)
      REG_NET_WIDTH:       frame_w = d;
      REG_NET_HEIGHT:      frame_h = d;
      REG_THRESHOLD_COUNT: thr_count = d[COUNT_W-1:0];
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(
    input logic [CFG_DATA_W-1:0] w,
    input logic [CFG_DATA_W-1:0] h,
    input logic [CFG_DATA_W-1:0] cnt
  );
    settle();
    write_reg(REG_NET_WIDTH, w);
    write_reg(REG_NET_HEIGHT, h);
    write_reg(REG_THRESHOLD_COUNT, cnt);
  endtask

  // ---------------------------------------------------------- random content

  function automatic logic signed [VALUE_W-1:0] pick_box_value(logic [1:0] slot);
    logic [VALUE_W-1:0] raw;
    int lim, v;
    raw = VALUE_W'($urandom);
    lim = int'((slot == SLOT_CX || slot == SLOT_W) ? frame_w : frame_h);
    lim = lim * 16;
    if ($urandom_range(0, 19) == 0) return $signed(raw);
    if (slot == SLOT_CX || slot == SLOT_CY) begin
      v = $urandom_range(0, lim + lim / 2 + 64);
      v = v - (lim / 4 + 32);
    end else if ($urandom_range(0, 9) == 0) begin
      v = 0 - int'($urandom_range(0, 64));
    end else begin
      v = $urandom_range(0, lim / 2 + 32);
    end
    return v[VALUE_W-1:0];
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_score();
    logic [VALUE_W-1:0] raw;
    int unsigned r;
    raw = VALUE_W'($urandom);
    r = $urandom_range(0, 19);
    if (r == 0) return $signed(raw);
    if (r == 1) return '0;
    if (r == 2) return 18'sd65535;
    return VALUE_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_threshold();
    logic [VALUE_W-1:0] raw;
    raw = VALUE_W'($urandom);
    if ($urandom_range(0, 9) == 0) return $signed(raw);
    return VALUE_W'($urandom_range(0, 40000));
  endfunction

  // box values and class scores, in a random order half of the time, last on the final element
  task automatic send_anchor();
    logic [OPCODE_W-1:0]       e_op [10];
    logic [INDEX_W-1:0]        e_idx [10];
    logic signed [VALUE_W-1:0] e_val [10];
    logic [OPCODE_W-1:0]       t_op;
    logic [INDEX_W-1:0]        t_idx;
    logic signed [VALUE_W-1:0] t_val;
    logic [1:0]                slot;
    int                        boxes, total, j, k;
    // now and then reuse box values held from an earlier anchor
    boxes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
    total = boxes + $urandom_range(1, 6);
    for (j = 0; j < total; j++) begin
      if (j < boxes) begin
        slot = (boxes == 4) ? j[1:0] : 2'($urandom_range(0, 3));
        e_op[j] = OP_BOX;
        e_idx[j] = {5'd0, slot};
        if ($urandom_range(0, 7) == 0) e_idx[j][INDEX_W-1:2] = 5'($urandom);
        e_val[j] = pick_box_value(slot);
      end else begin
        e_op[j] = OP_SCORE;
        e_idx[j] = 7'($urandom);
        e_val[j] = pick_score();
      end
    end
    if ($urandom_range(0, 1) == 1) begin
      for (j = total - 1; j > 0; j--) begin
        k = $urandom_range(0, j);
        t_op = e_op[j];   e_op[j] = e_op[k];   e_op[k] = t_op;
        t_idx = e_idx[j]; e_idx[j] = e_idx[k]; e_idx[k] = t_idx;
        t_val = e_val[j]; e_val[j] = e_val[k]; e_val[k] = t_val;
      end
    end
    for (j = 0; j < total; j++)
      push_element(e_op[j], e_idx[j], e_val[j], j == total - 1);
  endtask

  // ------------------------------------------------------------------- tests

  // reset frame, empty table count: the quarter scale default applies
  task automatic test_default_threshold();
    push_element(OP_BOX, SLOT_CX, 18'sd5120, 1'b0);
    push_element(OP_BOX, SLOT_CY, 18'sd5120, 1'b0);
    push_element(OP_BOX, SLOT_W, 18'sd1600, 1'b0);
    push_element(OP_BOX, SLOT_H, 18'sd800, 1'b0);
    push_element(OP_SCORE, 7'd5, 18'sd16384, 1'b1);
    push_element(OP_SCORE, 7'd3, 18'sd16383, 1'b1);
    // negative score clips to zero, so the anchor has no class
    push_element(OP_SCORE, 7'd7, -18'sd5, 1'b1);
    // equal score does not replace the earlier class
    push_element(OP_SCORE, 7'd10, 18'sd40000, 1'b0);
    push_element(OP_SCORE, 7'd20, 18'sd40000, 1'b1);
    push_element(OP_SCORE, 7'd127, 18'sd131071, 1'b1);
    push_element(OP_UNUSED, 7'd127, 18'sd131071, 1'b1);
    push_element(OP_THRESH, 7'd0, 18'sd0, 1'b1);
  endtask

  task automatic test_box_extremes();
    // slot taken from the low index bits only
    push_element(OP_BOX, 7'd4, -18'sd131072, 1'b0);
    push_element(OP_BOX, 7'd126, 18'sd131071, 1'b0);
    push_element(OP_BOX, 7'd127, 18'sd16, 1'b0);
    push_element(OP_SCORE, 7'd64, 18'sd65535, 1'b1);
    // centre far below the frame: top clamps, no room left
    push_element(OP_BOX, 7'd1, 18'sd131071, 1'b0);
    push_element(OP_SCORE, 7'd64, 18'sd65535, 1'b1);
  endtask

  task automatic test_threshold_table();
    int i;
    for (i = 0; i < CLASS_COUNT; i++) begin
      case (i)
        0: push_element(OP_THRESH, i[INDEX_W-1:0], 18'sd20000, 1'b0);
        2: push_element(OP_THRESH, i[INDEX_W-1:0], 18'sd131071, 1'b0);
        3: push_element(OP_THRESH, i[INDEX_W-1:0], -18'sd131072, 1'b0);
        default: push_element(OP_THRESH, i[INDEX_W-1:0], pick_threshold(), 1'b0);
      endcase
    end
    apply_settings(12'd640, 12'd480, 12'd128);
    push_element(OP_BOX, SLOT_CX, 18'sd320, 1'b0);
    push_element(OP_BOX, SLOT_CY, 18'sd7600, 1'b0);
    push_element(OP_BOX, SLOT_W, 18'sd2000, 1'b0);
    push_element(OP_BOX, SLOT_H, 18'sd1000, 1'b0);
    push_element(OP_SCORE, 7'd2, 18'sd65535, 1'b1);
    push_element(OP_SCORE, 7'd3, 18'sd1, 1'b1);
    // class beyond the table count falls back to entry zero
    apply_settings(12'd640, 12'd480, 12'd4);
    push_element(OP_SCORE, 7'd90, 18'sd19999, 1'b1);
    push_element(OP_SCORE, 7'd90, 18'sd20000, 1'b1);
  endtask

  task automatic test_zero_frame();
    apply_settings(12'd0, 12'd640, 12'd128);
    push_element(OP_SCORE, 7'd3, 18'sd65535, 1'b1);
    apply_settings(12'd640, 12'd0, 12'd0);
    push_element(OP_SCORE, 7'd3, 18'sd65535, 1'b1);
  endtask

  task automatic test_random_traffic();
    int unsigned phase, quota, r;
    logic [CFG_DATA_W-1:0] w, h, cnt;
    logic [INDEX_W-1:0] bidx;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin w = 12'd640;  h = 12'd640;  cnt = 12'd128; end
        1: begin w = 12'd1;    h = 12'd1;    cnt = 12'd0;   end
        2: begin w = 12'd4095; h = 12'd4095; cnt = 12'd128; end
        3: begin w = 12'd4095; h = 12'd1;    cnt = 12'd1;   end
        default: begin
          w = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(1, 4095))
                                          : CFG_DATA_W'($urandom_range(16, 800));
          h = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(1, 4095))
                                          : CFG_DATA_W'($urandom_range(16, 800));
          cnt = CFG_DATA_W'($urandom_range(0, 128));
        end
      endcase
      apply_settings(w, h, cnt);
      tx_idling = (phase[0] == 1'b0);
      rx_idling = (phase[1] == 1'b0);
      quota = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < quota) begin
        r = $urandom_range(0, 99);
        if (r < 78) begin
          send_anchor();
        end else if (r < 88) begin
          push_element(OP_THRESH, 7'($urandom), pick_threshold(), 1'($urandom));
        end else if (r < 93) begin
          push_element(OP_SCORE, 7'($urandom), pick_score(), 1'($urandom));
        end else if (r < 97) begin
          bidx = 7'($urandom);
          push_element(OP_BOX, bidx, pick_box_value(bidx[1:0]), 1'($urandom));
        end else begin
          push_element(OP_UNUSED, 7'($urandom), pick_score(), 1'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_default_threshold();
    test_box_extremes();
    test_threshold_table();
    test_zero_frame();
    test_random_traffic();
    settle();
    if (fail_count == 0) begin
      $display("detection_anchor_decode: match");
    end else begin
      $display("detection_anchor_decode: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/dad_pkg.sv
sv/detection_anchor_decode.sv
test/tb_detection_anchor_decode.sv
